// ===== src/pml_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pml_pkg
// Shared types, constants and arithmetic helpers for the 2D acoustic PML
// right-hand-side core.
// ----------------------------------------------------------------------------
package pml_pkg;

  localparam int NODES     = 16;
  localparam int CUB_NODES = 32;
  localparam int DW        = 32;
  localparam int NODE_W    = $clog2(NODES);
  localparam int CUB_W     = $clog2(CUB_NODES);
  localparam int PROD_W    = 2 * DW;
  localparam int QP_W      = PROD_W - 16;
  localparam int ACC_W     = QP_W + CUB_W;
  localparam int DIV_STEPS = DW + 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_INTERP  = 2'd0,
    OP_PROJECT = 2'd1,
    OP_NODAL   = 2'd2,
    OP_COEF    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_USE_WADG   = 2'd0,
    CFG_NODE_COUNT = 2'd1,
    CFG_CUB_COUNT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_DXY_F0 = 4'd0,
    ST_SY_DYX = 4'd1,
    ST_T_F3   = 4'd2,
    ST_DYX_F1 = 4'd3,
    ST_SX_DXY = 4'd4,
    ST_T_F4   = 4'd5,
    ST_SXY_F2 = 4'd6,
    ST_SX_SY  = 4'd7,
    ST_T_F5   = 4'd8,
    ST_SY_F3  = 4'd9,
    ST_SX_F4  = 4'd10,
    ST_C2_F2  = 4'd11
  } step_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INT_ISSUE,
    S_INT_DRAIN,
    S_STEP_MUL,
    S_STEP_ACT,
    S_DIV_START,
    S_DIV_WAIT,
    S_CUB_WRITE,
    S_PRJ_ISSUE,
    S_PRJ_DRAIN,
    S_OUT_WAIT
  } fsm_t;

  typedef struct packed {
    logic              mac_issue;
    logic              mac_first;
    logic              mac_last;
    logic              mac_proj;
    logic [2:0]        k;
    logic [CUB_W-1:0]  n_idx;
    logic [CUB_W-1:0]  i_idx;
    logic [NODE_W-1:0] node_idx;
    step_t             step;
    logic              step_mul;
    logic              step_act;
    logic              div_start;
    logic              crhs_we;
    logic              out_load;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] nn_last;
    logic [CUB_W-1:0]  nc_last;
    logic              wadg;
    logic              div_done;
    logic              out_free;
  } status_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic same;
    begin
      same = (&x[ACC_W-1:DW-1]) || !(|x[ACC_W-1:DW-1]);
      if (same) begin
        sat32 = x[DW-1:0];
      end else if (x[ACC_W-1]) begin
        sat32 = {1'b1, {(DW-1){1'b0}}};
      end else begin
        sat32 = {1'b0, {(DW-1){1'b1}}};
      end
    end
  endfunction

  function automatic logic signed [DW-1:0] field6(input logic [6*DW-1:0] row,
                                                  input logic [2:0] k);
    begin
      unique case (k)
        3'd0: field6 = row[0*DW +: DW];
        3'd1: field6 = row[1*DW +: DW];
        3'd2: field6 = row[2*DW +: DW];
        3'd3: field6 = row[3*DW +: DW];
        3'd4: field6 = row[4*DW +: DW];
        3'd5: field6 = row[5*DW +: DW];
        default: field6 = '0;
      endcase
    end
  endfunction

endpackage

// ===== src/pml_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pml_div
// Bit-serial signed Q16.16 divider: (num * 2^16) / den, truncated toward
// zero and saturated; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pml_div
  import pml_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic                 done,
  output logic                 busy,
  output logic signed [DW-1:0] quo
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [QP_W-1:0]      nq;
  logic [DW-1:0]        rem;
  logic [DW-1:0]        dmag;
  logic                 neg;
  logic                 zero_den;
  logic                 num_neg;
  logic                 num_zero;
  logic [DW:0]          rem_sh;
  logic                 qbit;
  logic [DW-1:0]        nmag;

  assign nmag   = num[DW-1] ? (~num + 1'b1) : num;
  assign rem_sh = {rem, nq[QP_W-1]};
  assign qbit   = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (den == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero_den <= (den == '0);
      num_neg  <= num[DW-1];
      num_zero <= (num == '0);
      neg      <= num[DW-1] ^ den[DW-1];
      dmag     <= den[DW-1] ? (~den + 1'b1) : den;
      nq       <= {nmag, 16'd0};
      rem      <= '0;
    end else if (busy) begin
      rem <= qbit ? DW'(rem_sh - {1'b0, dmag}) : rem_sh[DW-1:0];
      nq  <= {nq[QP_W-2:0], qbit};
    end
  end

  always_comb begin
    if (zero_den) begin
      if (num_zero) begin
        quo = '0;
      end else if (num_neg) begin
        quo = {1'b1, {(DW-1){1'b0}}};
      end else begin
        quo = {1'b0, {(DW-1){1'b1}}};
      end
    end else if (|nq[QP_W-1:DW-1]) begin
      quo = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      quo = neg ? -$signed({1'b0, nq[DW-2:0]}) : $signed({1'b0, nq[DW-2:0]});
    end
  end

endmodule

// ===== src/pml_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pml_dp
// Datapath: configuration registers, element stores, shared multiply-
// accumulate pipeline, cubature-point PML terms and output register.
// ----------------------------------------------------------------------------
module pml_dp
  import pml_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [5:0]           cfg_data,
  input  logic                 load,
  input  logic [1:0]           op,
  input  logic [4:0]           row_index,
  input  logic [4:0]           col_index,
  input  logic signed [DW-1:0] val_a,
  input  logic signed [DW-1:0] val_b,
  input  logic signed [DW-1:0] val_c,
  input  logic signed [DW-1:0] val_d,
  input  logic signed [DW-1:0] val_e,
  input  logic signed [DW-1:0] val_f,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [3:0]           node_index,
  output logic signed [DW-1:0] rhs_u,
  output logic signed [DW-1:0] rhs_v,
  output logic signed [DW-1:0] rhs_p,
  output logic signed [DW-1:0] rhs_u_aux,
  output logic signed [DW-1:0] rhs_v_aux,
  output logic signed [DW-1:0] rhs_p_aux,
  output logic                 last_node
);

  logic       use_wadg;
  logic [4:0] node_count;
  logic [5:0] cub_count;

  logic signed [DW-1:0] interp_mem [CUB_NODES*NODES];
  logic signed [DW-1:0] proj_mem   [NODES*CUB_NODES];
  logic [6*DW-1:0]      nodal_mem  [NODES];
  logic [3*DW-1:0]      coef_mem   [CUB_NODES];
  logic [6*DW-1:0]      crhs_mem   [CUB_NODES];

  logic signed [DW-1:0] interp_rd;
  logic signed [DW-1:0] proj_rd;
  logic [6*DW-1:0]      nodal_rd;
  logic [3*DW-1:0]      coef_rd;
  logic [6*DW-1:0]      crhs_rd;

  logic       s1_valid, s1_first, s1_last, s1_proj;
  logic [2:0] s1_k;
  logic       s2_valid, s2_first, s2_last, s2_proj;
  logic [2:0] s2_k;

  logic signed [DW-1:0]     mac_a, mac_b, step_a, step_b, mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  qpe;
  logic signed [ACC_W-1:0]  macc;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  tacc;

  logic signed [DW-1:0] f   [6];
  logic signed [DW-1:0] res [6];
  logic signed [DW-1:0] r   [6];
  logic signed [DW-1:0] tmp;
  logic signed [DW-1:0] tq;

  logic signed [DW-1:0] sx, sy, c2, dxy, dyx, sxy;
  logic                 div_done, div_busy;
  logic signed [DW-1:0] div_quo;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      use_wadg   <= 1'b0;
      node_count <= 5'd15;
      cub_count  <= 6'd28;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_USE_WADG:   use_wadg   <= cfg_data[0];
        CFG_NODE_COUNT: node_count <= cfg_data[4:0];
        CFG_CUB_COUNT:  cub_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    status.wadg = use_wadg;
    if (node_count == '0) begin
      status.nn_last = '0;
    end else if (node_count > 5'(NODES)) begin
      status.nn_last = NODE_W'(NODES - 1);
    end else begin
      status.nn_last = NODE_W'(node_count - 5'd1);
    end
    if (cub_count == '0) begin
      status.nc_last = '0;
    end else if (cub_count > 6'(CUB_NODES)) begin
      status.nc_last = CUB_W'(CUB_NODES - 1);
    end else begin
      status.nc_last = CUB_W'(cub_count - 6'd1);
    end
    status.div_done = div_done;
    status.out_free = !out_valid || !out_stall;
  end

  // element stores
  always_ff @(posedge clk) begin
    if (load) begin
      unique case (op_t'(op))
        OP_INTERP: begin
          if (!col_index[4]) interp_mem[{row_index, col_index[3:0]}] <= val_a;
        end
        OP_PROJECT: begin
          if (!row_index[4]) proj_mem[{row_index[3:0], col_index}] <= val_a;
        end
        OP_NODAL: begin
          if (!row_index[4]) begin
            nodal_mem[row_index[3:0]] <= {val_f, val_e, val_d, val_c, val_b, val_a};
          end
        end
        OP_COEF: coef_mem[row_index] <= {val_c, val_b, val_a};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    interp_rd <= interp_mem[{cmd.n_idx, cmd.i_idx[NODE_W-1:0]}];
    proj_rd   <= proj_mem[{cmd.node_idx, cmd.i_idx}];
    nodal_rd  <= nodal_mem[cmd.i_idx[NODE_W-1:0]];
    coef_rd   <= coef_mem[cmd.n_idx];
    crhs_rd   <= crhs_mem[cmd.i_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.crhs_we) begin
      crhs_mem[cmd.n_idx] <= {r[5], r[4], r[3], r[2], r[1], r[0]};
    end
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.mac_issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= cmd.mac_first;
    s1_last  <= cmd.mac_last;
    s1_proj  <= cmd.mac_proj;
    s1_k     <= cmd.k;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_proj  <= s1_proj;
    s2_k     <= s1_k;
  end

  assign mac_a = s1_proj ? proj_rd : interp_rd;
  assign mac_b = s1_proj ? field6(crhs_rd, s1_k) : field6(nodal_rd, s1_k);
  assign mul_a = s1_valid ? mac_a : step_a;
  assign mul_b = s1_valid ? mac_b : step_b;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign qpe     = ACC_W'($signed(prod[PROD_W-1:16]));
  assign acc_sum = s2_first ? qpe : macc + qpe;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      macc <= acc_sum;
      if (s2_last) begin
        if (s2_proj) begin
          res[s2_k] <= sat32(acc_sum);
        end else begin
          f[s2_k] <= sat32(acc_sum);
        end
      end
    end
  end

  // cubature-point terms
  assign sx  = coef_rd[0*DW +: DW];
  assign sy  = coef_rd[1*DW +: DW];
  assign c2  = coef_rd[2*DW +: DW];
  assign dxy = sat32(ACC_W'(sx) - ACC_W'(sy));
  assign dyx = sat32(ACC_W'(sy) - ACC_W'(sx));
  assign sxy = sat32(ACC_W'(sx) + ACC_W'(sy));

  always_comb begin
    unique case (cmd.step)
      ST_DXY_F0: begin step_a = dxy; step_b = f[0]; end
      ST_SY_DYX: begin step_a = sy;  step_b = dyx;  end
      ST_T_F3:   begin step_a = tmp; step_b = f[3]; end
      ST_DYX_F1: begin step_a = dyx; step_b = f[1]; end
      ST_SX_DXY: begin step_a = sx;  step_b = dxy;  end
      ST_T_F4:   begin step_a = tmp; step_b = f[4]; end
      ST_SXY_F2: begin step_a = sxy; step_b = f[2]; end
      ST_SX_SY:  begin step_a = sx;  step_b = sy;   end
      ST_T_F5:   begin step_a = tmp; step_b = f[5]; end
      ST_SY_F3:  begin step_a = sy;  step_b = f[3]; end
      ST_SX_F4:  begin step_a = sx;  step_b = f[4]; end
      ST_C2_F2:  begin step_a = c2;  step_b = f[2]; end
      default:   begin step_a = '0;  step_b = '0;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      tq <= div_quo;
    end else if (cmd.step_act) begin
      unique case (cmd.step)
        ST_DXY_F0, ST_DYX_F1:           tacc <= -qpe;
        ST_SY_DYX, ST_SX_DXY, ST_SX_SY: tmp  <= sat32(qpe);
        ST_T_F3:   r[0] <= sat32(tacc - qpe);
        ST_T_F4:   r[1] <= sat32(tacc - qpe);
        ST_SXY_F2: tq   <= sat32(qpe);
        ST_T_F5:   r[2] <= sat32(-ACC_W'(tq) - qpe);
        ST_SY_F3:  r[3] <= sat32(ACC_W'(f[0]) - qpe);
        ST_SX_F4:  r[4] <= sat32(ACC_W'(f[1]) - qpe);
        ST_C2_F2:  r[5] <= use_wadg ? sat32(qpe) : f[2];
        default: ;
      endcase
    end
  end

  pml_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (tq),
    .den   (c2),
    .done  (div_done),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      node_index <= cmd.node_idx;
      last_node  <= cmd.out_last;
      rhs_u      <= res[0];
      rhs_v      <= res[1];
      rhs_p      <= res[2];
      rhs_u_aux  <= res[3];
      rhs_v_aux  <= res[4];
      rhs_p_aux  <= res[5];
    end
  end

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten before transfer");

  a_mul_conflict : assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && cmd.step_mul))
    else $error("multiplier claimed by both pipeline and step");

  a_div_quiet : assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !(cmd.step_act || cmd.mac_issue || cmd.div_start))
    else $error("datapath active during division");

endmodule

// ===== src/pml_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pml_ctrl
// Controller: sequences loads, interpolation, cubature-point terms,
// projection and result hand-off.
// ----------------------------------------------------------------------------
module pml_ctrl
  import pml_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    start_compute,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  fsm_t              state, state_next;
  logic [CUB_W-1:0]  n_idx, n_idx_next;
  logic [CUB_W-1:0]  i_idx, i_idx_next;
  logic [2:0]        k, k_next;
  logic [NODE_W-1:0] node, node_next;
  step_t             step, step_next;
  logic              drain, drain_next;
  logic              int_last, prj_last;

  assign int_last = (i_idx == CUB_W'(status.nn_last));
  assign prj_last = (i_idx == status.nc_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n_idx <= '0;
      i_idx <= '0;
      k     <= '0;
      node  <= '0;
      step  <= ST_DXY_F0;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      n_idx <= n_idx_next;
      i_idx <= i_idx_next;
      k     <= k_next;
      node  <= node_next;
      step  <= step_next;
      drain <= drain_next;
    end
  end

  always_comb begin
    state_next = state;
    n_idx_next = n_idx;
    i_idx_next = i_idx;
    k_next     = k;
    node_next  = node;
    step_next  = step;
    drain_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && start_compute) begin
          state_next = S_INT_ISSUE;
          n_idx_next = '0;
          i_idx_next = '0;
          k_next     = '0;
        end
      end
      S_INT_ISSUE: begin
        if (int_last) begin
          i_idx_next = '0;
          if (k == 3'd5) begin
            k_next     = '0;
            state_next = S_INT_DRAIN;
          end else begin
            k_next = k + 3'd1;
          end
        end else begin
          i_idx_next = i_idx + 1'b1;
        end
      end
      S_INT_DRAIN: begin
        drain_next = 1'b1;
        if (drain) begin
          step_next  = ST_DXY_F0;
          state_next = S_STEP_MUL;
        end
      end
      S_STEP_MUL: state_next = S_STEP_ACT;
      S_STEP_ACT: begin
        if (step == ST_SXY_F2 && status.wadg) begin
          state_next = S_DIV_START;
        end else if (step == ST_C2_F2) begin
          state_next = S_CUB_WRITE;
        end else begin
          step_next  = step_t'(step + 4'd1);
          state_next = S_STEP_MUL;
        end
      end
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (status.div_done) begin
          step_next  = ST_SX_SY;
          state_next = S_STEP_MUL;
        end
      end
      S_CUB_WRITE: begin
        if (n_idx == status.nc_last) begin
          node_next  = '0;
          i_idx_next = '0;
          k_next     = '0;
          state_next = S_PRJ_ISSUE;
        end else begin
          n_idx_next = n_idx + 1'b1;
          state_next = S_INT_ISSUE;
        end
      end
      S_PRJ_ISSUE: begin
        if (prj_last) begin
          i_idx_next = '0;
          if (k == 3'd5) begin
            k_next     = '0;
            state_next = S_PRJ_DRAIN;
          end else begin
            k_next = k + 3'd1;
          end
        end else begin
          i_idx_next = i_idx + 1'b1;
        end
      end
      S_PRJ_DRAIN: begin
        drain_next = 1'b1;
        if (drain) state_next = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (status.out_free) begin
          if (node == status.nn_last) begin
            state_next = S_IDLE;
          end else begin
            node_next  = node + 1'b1;
            state_next = S_PRJ_ISSUE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != S_IDLE);
    cmd           = '0;
    cmd.k         = k;
    cmd.n_idx     = n_idx;
    cmd.i_idx     = i_idx;
    cmd.node_idx  = node;
    cmd.step      = step;
    cmd.out_last  = (node == status.nn_last);
    unique case (state)
      S_INT_ISSUE: begin
        cmd.mac_issue = 1'b1;
        cmd.mac_first = (i_idx == '0);
        cmd.mac_last  = int_last;
      end
      S_PRJ_ISSUE: begin
        cmd.mac_issue = 1'b1;
        cmd.mac_proj  = 1'b1;
        cmd.mac_first = (i_idx == '0);
        cmd.mac_last  = prj_last;
      end
      S_STEP_MUL:  cmd.step_mul  = 1'b1;
      S_STEP_ACT:  cmd.step_act  = 1'b1;
      S_DIV_START: cmd.div_start = 1'b1;
      S_CUB_WRITE: cmd.crhs_we   = 1'b1;
      S_OUT_WAIT:  cmd.out_load  = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== src/pml_acoustic_rhs_2d_core.sv =====
`timescale 1ns / 1ps
// Load items transfer one per cycle while the core is idle; an item with start_compute blocks input until done.
// Compute: per cubature node interpolation and PML terms (plus the serial divider in wadg mode),
// then per nodal point a projection through the one shared multiplier.
// Reset (rst, synchronous) clears control and config; element stores stay unwritten.
// ----------------------------------------------------------------------------
// pml_acoustic_rhs_2d_core
// Per-element PML right-hand side for 2D acoustics in signed Q16.16.
// ----------------------------------------------------------------------------
module pml_acoustic_rhs_2d_core
  import pml_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [5:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           op,
  input  logic [4:0]           row_index,
  input  logic [4:0]           col_index,
  input  logic signed [DW-1:0] val_a,
  input  logic signed [DW-1:0] val_b,
  input  logic signed [DW-1:0] val_c,
  input  logic signed [DW-1:0] val_d,
  input  logic signed [DW-1:0] val_e,
  input  logic signed [DW-1:0] val_f,
  input  logic                 start_compute,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           node_index,
  output logic signed [DW-1:0] rhs_u,
  output logic signed [DW-1:0] rhs_v,
  output logic signed [DW-1:0] rhs_p,
  output logic signed [DW-1:0] rhs_u_aux,
  output logic signed [DW-1:0] rhs_v_aux,
  output logic signed [DW-1:0] rhs_p_aux,
  output logic                 last_node
);

  cmd_t    cmd;
  status_t status;

  pml_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .start_compute (start_compute),
    .in_stall      (in_stall),
    .status        (status),
    .cmd           (cmd)
  );

  pml_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .load       (in_valid && !in_stall),
    .op         (op),
    .row_index  (row_index),
    .col_index  (col_index),
    .val_a      (val_a),
    .val_b      (val_b),
    .val_c      (val_c),
    .val_d      (val_d),
    .val_e      (val_e),
    .val_f      (val_f),
    .cmd        (cmd),
    .status     (status),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .node_index (node_index),
    .rhs_u      (rhs_u),
    .rhs_v      (rhs_v),
    .rhs_p      (rhs_p),
    .rhs_u_aux  (rhs_u_aux),
    .rhs_v_aux  (rhs_v_aux),
    .rhs_p_aux  (rhs_p_aux),
    .last_node  (last_node)
  );

endmodule

// ===== verif/pml_rhs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pml_rhs_checker
// Watches the configuration port and both channels of the PML rhs core. It
// keeps its own copy of the element stores, computes the expected nodal rhs
// contributions when a compute is started, and compares every output
// transfer with the oldest expected result.
// ----------------------------------------------------------------------------
module pml_rhs_checker
  import pml_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [5:0]           cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           op,
  input  logic [4:0]           row_index,
  input  logic [4:0]           col_index,
  input  logic signed [DW-1:0] val_a,
  input  logic signed [DW-1:0] val_b,
  input  logic signed [DW-1:0] val_c,
  input  logic signed [DW-1:0] val_d,
  input  logic signed [DW-1:0] val_e,
  input  logic signed [DW-1:0] val_f,
  input  logic                 start_compute,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [3:0]           node_index,
  input  logic signed [DW-1:0] rhs_u,
  input  logic signed [DW-1:0] rhs_v,
  input  logic signed [DW-1:0] rhs_p,
  input  logic signed [DW-1:0] rhs_u_aux,
  input  logic signed [DW-1:0] rhs_v_aux,
  input  logic signed [DW-1:0] rhs_p_aux,
  input  logic                 last_node,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    logic [3:0]       node;
    logic [5:0][31:0] rhs;
    logic             last;
  } node_rhs_t;

  int        interp[CUB_NODES*NODES];
  int        project[NODES*CUB_NODES];
  int        nodal[NODES*6];
  int        coef[CUB_NODES*3];
  int        cub_rhs[CUB_NODES*6];
  logic      wadg;
  int        node_cnt;
  int        cub_cnt;
  node_rhs_t expected_rhs[$];

  function automatic longint clip(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint qm(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic longint qdiv(longint a, longint d);
    if (d == 0) begin
      if (a > 0) return 64'sd2147483647;
      if (a < 0) return -64'sd2147483648;
      return 0;
    end
    return clip((a * 65536) / d);
  endfunction

  task automatic predict_element();
    int        nn;
    int        nc;
    longint    f[6];
    longint    acc;
    longint    sx, sy, c2, dxy, dyx, sxy, t;
    node_rhs_t r;
    nn = node_cnt < 1 ? 1 : node_cnt;
    if (nn > NODES) nn = NODES;
    nc = cub_cnt < 1 ? 1 : cub_cnt;
    if (nc > CUB_NODES) nc = CUB_NODES;
    for (int n = 0; n < nc; n++) begin
      for (int k = 0; k < 6; k++) begin
        acc = 0;
        for (int i = 0; i < nn; i++) acc += qm(interp[n*NODES+i], nodal[i*6+k]);
        f[k] = clip(acc);
      end
      sx  = coef[n*3+0];
      sy  = coef[n*3+1];
      c2  = coef[n*3+2];
      dxy = clip(sx - sy);
      dyx = clip(sy - sx);
      sxy = clip(sx + sy);
      cub_rhs[n*6+0] = int'(clip(-qm(dxy, f[0]) - qm(clip(qm(sy, dyx)), f[3])));
      cub_rhs[n*6+1] = int'(clip(-qm(dyx, f[1]) - qm(clip(qm(sx, dxy)), f[4])));
      t = clip(qm(sxy, f[2]));
      if (wadg) t = qdiv(t, c2);
      cub_rhs[n*6+2] = int'(clip(-t - qm(clip(qm(sx, sy)), f[5])));
      cub_rhs[n*6+3] = int'(clip(f[0] - qm(sy, f[3])));
      cub_rhs[n*6+4] = int'(clip(f[1] - qm(sx, f[4])));
      cub_rhs[n*6+5] = int'(wadg ? clip(qm(c2, f[2])) : f[2]);
    end
    for (int n = 0; n < nn; n++) begin
      r.node = n[3:0];
      for (int k = 0; k < 6; k++) begin
        acc = 0;
        for (int i = 0; i < nc; i++) acc += qm(project[n*CUB_NODES+i], cub_rhs[i*6+k]);
        r.rhs[k] = 32'(clip(acc));
      end
      r.last = (n + 1 == nn);
      expected_rhs.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    node_rhs_t        exp_r;
    logic [5:0][31:0] got;
    if (rst) begin
      wadg     = 1'b0;
      node_cnt = 15;
      cub_cnt  = 28;
      errors   = 0;
      expected_rhs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_USE_WADG:   wadg = cfg_data[0];
          CFG_NODE_COUNT: node_cnt = int'(cfg_data[4:0]);
          CFG_CUB_COUNT:  cub_cnt = int'(cfg_data);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {rhs_p_aux, rhs_v_aux, rhs_u_aux, rhs_p, rhs_v, rhs_u};
        if (expected_rhs.size() == 0) begin
          $display("%0t: unexpected result transfer node %0d", $time, node_index);
          errors++;
        end else begin
          exp_r = expected_rhs.pop_front();
          if (node_index !== exp_r.node) begin
            $display("%0t: node_index expected %0d actual %0d", $time, exp_r.node, node_index);
            errors++;
          end
          for (int k = 0; k < 6; k++) begin
            if (got[k] !== exp_r.rhs[k]) begin
              $display("%0t: node %0d rhs field %0d expected %h actual %h",
                       $time, exp_r.node, k, exp_r.rhs[k], got[k]);
              errors++;
            end
          end
          if (last_node !== exp_r.last) begin
            $display("%0t: last_node expected %0b actual %0b", $time, exp_r.last, last_node);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (op_t'(op))
          OP_INTERP:  if (col_index < NODES) interp[row_index*NODES+col_index] = val_a;
          OP_PROJECT: if (row_index < NODES) project[row_index*CUB_NODES+col_index] = val_a;
          OP_NODAL: begin
            if (row_index < NODES) begin
              nodal[row_index*6+0] = val_a;
              nodal[row_index*6+1] = val_b;
              nodal[row_index*6+2] = val_c;
              nodal[row_index*6+3] = val_d;
              nodal[row_index*6+4] = val_e;
              nodal[row_index*6+5] = val_f;
            end
          end
          default: begin
            coef[row_index*3+0] = val_a;
            coef[row_index*3+1] = val_b;
            coef[row_index*3+2] = val_c;
          end
        endcase
        if (start_compute) predict_element();
      end
    end
    pending = expected_rhs.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the PML rhs core with matrix, field and coefficient loads over a
// range of node and cubature counts, with and without the wadg variant, under
// random idling on both channels. The checker beside the core predicts and
// compares every result transfer.
// ----------------------------------------------------------------------------
module tb_top;
  import pml_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [5:0]           cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           op;
  logic [4:0]           row_index;
  logic [4:0]           col_index;
  logic signed [DW-1:0] val_a, val_b, val_c, val_d, val_e, val_f;
  logic                 start_compute;
  logic                 out_valid;
  logic                 out_stall;
  logic [3:0]           node_index;
  logic signed [DW-1:0] rhs_u, rhs_v, rhs_p, rhs_u_aux, rhs_v_aux, rhs_p_aux;
  logic                 last_node;
  int                   errors;
  int                   pending;

  int   tx_pct;
  int   rx_pct;
  logic hold_req;
  int   hold_cnt;
  int   quiet_cycles;
  int   item_count;
  int   tb_nn;
  int   tb_nc;
  logic w_interp[CUB_NODES][NODES];
  logic w_proj[NODES][CUB_NODES];
  logic w_nodal[NODES];
  logic w_coef[CUB_NODES];

  pml_acoustic_rhs_2d_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .row_index(row_index),
    .col_index(col_index), .val_a(val_a), .val_b(val_b), .val_c(val_c), .val_d(val_d),
    .val_e(val_e), .val_f(val_f), .start_compute(start_compute), .out_valid(out_valid),
    .out_stall(out_stall), .node_index(node_index), .rhs_u(rhs_u), .rhs_v(rhs_v),
    .rhs_p(rhs_p), .rhs_u_aux(rhs_u_aux), .rhs_v_aux(rhs_v_aux), .rhs_p_aux(rhs_p_aux),
    .last_node(last_node)
  );

  pml_rhs_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .row_index(row_index),
    .col_index(col_index), .val_a(val_a), .val_b(val_b), .val_c(val_c), .val_d(val_d),
    .val_e(val_e), .val_f(val_f), .start_compute(start_compute), .out_valid(out_valid),
    .out_stall(out_stall), .node_index(node_index), .rhs_u(rhs_u), .rhs_v(rhs_v),
    .rhs_p(rhs_p), .rhs_u_aux(rhs_u_aux), .rhs_v_aux(rhs_v_aux), .rhs_p_aux(rhs_p_aux),
    .last_node(last_node), .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall = 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_cnt  = 400;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < rx_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_word();
    if ($urandom_range(1)) return $urandom();
    return 32'($urandom_range(32'h3ffff)) - 32'h20000;
  endfunction

  task automatic send(op_t o, logic [4:0] r, logic [4:0] c, logic [31:0] a,
                      logic [31:0] b, logic [31:0] cc, logic [31:0] d,
                      logic [31:0] e, logic [31:0] f, logic sc);
    if ($urandom_range(99) < tx_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid      = 1'b1;
    op            = o;
    row_index     = r;
    col_index     = c;
    val_a         = a;
    val_b         = b;
    val_c         = cc;
    val_d         = d;
    val_e         = e;
    val_f         = f;
    start_compute = sc;
    do @(posedge clk); while (in_stall);
    case (o)
      OP_INTERP:  if (c < NODES) w_interp[r][c] = 1'b1;
      OP_PROJECT: if (r < NODES) w_proj[r][c] = 1'b1;
      OP_NODAL:   if (r < NODES) w_nodal[r] = 1'b1;
      default:    w_coef[r] = 1'b1;
    endcase
    item_count++;
    @(negedge clk);
  endtask

  task automatic send_rand(op_t o, logic [4:0] r, logic [4:0] c, logic sc);
    send(o, r, c, rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
         rand_word(), sc);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [5:0] d);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_NODE_COUNT) begin
      tb_nn = int'(d[4:0]);
      tb_nn = tb_nn < 1 ? 1 : (tb_nn > NODES ? NODES : tb_nn);
    end else if (idx == CFG_CUB_COUNT) begin
      tb_nc = int'(d);
      tb_nc = tb_nc < 1 ? 1 : (tb_nc > CUB_NODES ? CUB_NODES : tb_nc);
    end
  endtask

  task automatic setup(logic w, logic [5:0] nn, logic [5:0] nc);
    drain();
    cfg_write(CFG_USE_WADG, {5'd0, w});
    cfg_write(CFG_NODE_COUNT, nn);
    cfg_write(CFG_CUB_COUNT, nc);
  endtask

  task automatic run_element(int loads);
    op_t o;
    for (int j = 0; j < loads; j++) begin
      o = op_t'($urandom_range(3));
      if ($urandom_range(9) == 0)
        send_rand(o, 5'($urandom_range(31)), 5'($urandom_range(31)), 1'b0);
      else if (o == OP_INTERP || o == OP_COEF)
        send_rand(o, 5'($urandom_range(tb_nc - 1)), 5'($urandom_range(tb_nn - 1)), 1'b0);
      else
        send_rand(o, 5'($urandom_range(tb_nn - 1)), 5'($urandom_range(tb_nc - 1)), 1'b0);
    end
    for (int n = 0; n < tb_nc; n++) begin
      if (!w_coef[n]) send_rand(OP_COEF, 5'(n), 5'd0, 1'b0);
      for (int i = 0; i < tb_nn; i++) begin
        if (!w_interp[n][i]) send_rand(OP_INTERP, 5'(n), 5'(i), 1'b0);
        if (!w_proj[i][n]) send_rand(OP_PROJECT, 5'(i), 5'(n), 1'b0);
      end
    end
    for (int i = 0; i < tb_nn; i++)
      if (!w_nodal[i]) send_rand(OP_NODAL, 5'(i), 5'd0, 1'b0);
    o = op_t'($urandom_range(3));
    send_rand(o, 5'($urandom_range(tb_nn - 1)), 5'($urandom_range(tb_nn - 1)), 1'b1);
  endtask

  initial begin
    logic [5:0] ph_w[8]  = '{0, 1, 0, 1, 0, 1, 0, 1};
    logic [5:0] ph_nn[8] = '{2, 3, 5, 4, 0, 31, 1, 2};
    logic [5:0] ph_nc[8] = '{3, 4, 6, 2, 0, 1, 63, 2};
    int         phase_start;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_USE_WADG;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_INTERP;
    row_index = '0;
    col_index = '0;
    {val_a, val_b, val_c, val_d, val_e, val_f} = '0;
    start_compute = 1'b0;
    out_stall = 1'b0;
    hold_req = 1'b0;
    hold_cnt = 0;
    quiet_cycles = 0;
    item_count = 0;
    tx_pct = 0;
    rx_pct = 0;
    tb_nn = 15;
    tb_nc = 28;
    for (int n = 0; n < CUB_NODES; n++) begin
      w_coef[n] = 1'b0;
      for (int i = 0; i < NODES; i++) begin
        w_interp[n][i] = 1'b0;
        w_proj[i][n] = 1'b0;
      end
    end
    for (int i = 0; i < NODES; i++) w_nodal[i] = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed: extremes, out-of-range addresses, zero c2 in wadg mode
    setup(1'b0, 6'd1, 6'd1);
    send(OP_INTERP, 5'd0, 5'd0, 32'h7fffffff, 0, 0, 0, 0, 0, 1'b0);
    send(OP_PROJECT, 5'd0, 5'd0, 32'h80000000, 0, 0, 0, 0, 0, 1'b0);
    send(OP_NODAL, 5'd0, 5'd0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
         32'h00000001, 32'h80000000, 32'h7fffffff, 1'b0);
    send(OP_COEF, 5'd0, 5'd0, 32'h7fffffff, 32'h80000000, 32'h00010000, 0, 0, 0, 1'b0);
    send(OP_INTERP, 5'd31, 5'd16, 32'h12345678, 0, 0, 0, 0, 0, 1'b0);
    send(OP_PROJECT, 5'd20, 5'd31, 32'h12345678, 0, 0, 0, 0, 0, 1'b0);
    send(OP_NODAL, 5'd31, 5'd0, 1, 2, 3, 4, 5, 6, 1'b0);
    send(OP_COEF, 5'd0, 5'd0, 32'h7fffffff, 32'h80000000, 32'h00010000, 0, 0, 0, 1'b1);
    setup(1'b1, 6'd1, 6'd1);
    send(OP_COEF, 5'd0, 5'd0, 32'h00020000, 32'h00008000, 32'h0, 0, 0, 0, 1'b1);
    send(OP_NODAL, 5'd0, 5'd0, 32'hfffe0000, 32'h00030000, 32'hfff00000,
         32'h00001000, 32'hffff8000, 32'h00050000, 1'b1);
    send(OP_INTERP, 5'd0, 5'd0, 32'h00010000, 0, 0, 0, 0, 0, 1'b0);
    send(OP_PROJECT, 5'd0, 5'd0, 32'h00010000, 0, 0, 0, 0, 0, 1'b0);
    send(OP_COEF, 5'd0, 5'd0, 32'h00018000, 32'hffff0000, 32'hfffe0000, 0, 0, 0, 1'b1);
    send(OP_COEF, 5'd0, 5'd0, 32'h00018000, 32'hffff0000, 32'h00000001, 0, 0, 0, 1'b1);

    for (int p = 0; p < 8; p++) begin
      setup(ph_w[p][0], ph_nn[p], ph_nc[p]);
      tx_pct = p < 2 ? 9 : (p < 4 ? 60 : 0);
      rx_pct = p < 2 ? 60 : (p < 4 ? 9 : 0);
      if (p == 0) hold_req = 1'b1;
      phase_start = item_count;
      if (p == 5 || p == 6) run_element($urandom_range(0, 4));
      else while (item_count - phase_start < 25) run_element($urandom_range(0, 8));
    end

    drain();
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
